[hdl/nnalu_pkg.sv]
// Package for the natural-number ALU: opcodes, result codes, beat types,
// sequencer states and the status bundle of the shared adder.
// No dependencies.
package nnalu_pkg;

  localparam int WIDTH_DEF = 32;
  localparam int FIELD_W   = 32;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MOD = 3'd4;
  localparam logic [2:0] OP_CMP = 3'd5;
  localparam logic [2:0] OP_GCD = 3'd6;

  localparam logic [1:0] ORD_LESS    = 2'd0;
  localparam logic [1:0] ORD_EQUAL   = 2'd1;
  localparam logic [1:0] ORD_GREATER = 2'd2;

  localparam logic [1:0] FLT_NONE    = 2'd0;
  localparam logic [1:0] FLT_UNDER   = 2'd1;
  localparam logic [1:0] FLT_ZERODIV = 2'd2;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [FIELD_W-1:0] operand_a;
    logic [FIELD_W-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic [1:0]         order;
    logic [1:0]         fault;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALU,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic carry;
    logic zero;
  } unit_stat_t;

endpackage

[hdl/nnalu_addsub.sv]
// Shared adder/subtractor of the natural-number ALU.
// Depends on nnalu_pkg (unit_stat_t).
module nnalu_addsub #(
  parameter int WIDTH = nnalu_pkg::WIDTH_DEF
) (
  input  logic [WIDTH:0]       lhs,
  input  logic [WIDTH-1:0]     rhs,
  input  logic                 sub,
  output logic [WIDTH:0]       res,
  output nnalu_pkg::unit_stat_t stat
);

  logic [WIDTH:0]   rhs_ext;
  logic [WIDTH:0]   rhs_eff;
  logic [WIDTH+1:0] sum;

  assign rhs_ext = {1'b0, rhs};
  assign rhs_eff = sub ? ~rhs_ext : rhs_ext;
  assign sum     = {1'b0, lhs} + {1'b0, rhs_eff} + (WIDTH+2)'(sub);

  assign res        = sum[WIDTH:0];
  // carry out of a subtract means no borrow: lhs >= rhs
  assign stat.carry = sum[WIDTH+1];
  assign stat.zero  = (sum[WIDTH-1:0] == '0);

endmodule

[hdl/natural_number_alu_with_gcd.sv]
// Top level of the natural-number ALU with Euclidean GCD.
// Depends on nnalu_pkg and nnalu_addsub.
//
// Usage:
//   in_valid / in_stall / in_data carry one beat: opcode and two operands.
//   out_valid / out_stall / out_data carry one result beat: value, order
//   (three-way compare code) and fault (underflow or zero divisor).
//   Every input beat gives exactly one result beat, in order.
// Sequencing (states from the accepting edge to out_valid):
//   add, sub, compare: ALU, FIN; zero divisor: CHK, FIN; unused opcode: FIN.
//   multiply: MUL, one bit a cycle (shift-and-add), then FIN.
//   divide, remainder: CHK, DIV one bit a cycle (restoring division), then FIN.
//   gcd: one CHK and DIV pass per remainder round, then FIN; up to about
//   1.44 * WIDTH rounds.
//   All work goes through one WIDTH+1 bit adder, so only one item is in
//   flight; in_stall is high from the accepting edge until the sequencer
//   is back in idle, so a new beat can be taken in the same cycle that out_valid rises.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_valid. A finished result sits in the output register; the next beat
// is taken while it waits. If out_stall holds the register, a later item
// waits in its final state until the register frees up.
module natural_number_alu_with_gcd #(
  parameter int WIDTH = nnalu_pkg::WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  nnalu_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output nnalu_pkg::out_item_t out_data
);

  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam int FW    = nnalu_pkg::FIELD_W;

  nnalu_pkg::state_t    state_r, state_nxt;
  logic [2:0]           op_r, op_nxt;
  logic [WIDTH-1:0]     x_r, x_nxt;
  logic [WIDTH-1:0]     y_r, y_nxt;
  logic [WIDTH-1:0]     acc_r, acc_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [1:0]           ord_r, ord_nxt;
  logic [1:0]           flt_r, flt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  nnalu_pkg::out_item_t out_data_r, out_data_nxt;

  // shared adder hookup
  logic [WIDTH:0]        u_lhs;
  logic [WIDTH-1:0]      u_rhs;
  logic                  u_sub;
  logic [WIDTH:0]        u_res;
  nnalu_pkg::unit_stat_t u_stat;

  logic             in_fire;
  logic             out_free;
  logic             cnt_last;
  logic             y_zero;
  logic [WIDTH-1:0] rem_step;
  logic [WIDTH-1:0] quo_step;

  nnalu_addsub #(
    .WIDTH (WIDTH)
  ) u_addsub (
    .lhs  (u_lhs),
    .rhs  (u_rhs),
    .sub  (u_sub),
    .res  (u_res),
    .stat (u_stat)
  );

  assign in_stall  = (state_r != nnalu_pkg::ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cnt_last  = (cnt_r == CNT_W'(WIDTH - 1));
  assign y_zero    = (y_r == '0);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Restoring division step: keep the trial difference on no borrow,
  // else restore the shifted partial remainder.
  assign rem_step = u_stat.carry ? u_res[WIDTH-1:0] : u_lhs[WIDTH-1:0];
  assign quo_step = {x_r[WIDTH-2:0], u_stat.carry};

  // Operand select for the shared adder
  always_comb begin
    unique case (state_r)
      nnalu_pkg::ST_MUL: begin
        u_lhs = {1'b0, acc_r};
        u_rhs = x_r;
        u_sub = 1'b0;
      end
      nnalu_pkg::ST_DIV: begin
        u_lhs = {acc_r, x_r[WIDTH-1]};
        u_rhs = y_r;
        u_sub = 1'b1;
      end
      default: begin
        u_lhs = {1'b0, x_r};
        u_rhs = y_r;
        u_sub = (op_r != nnalu_pkg::OP_ADD);
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nnalu_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (in_data.opcode) inside
            nnalu_pkg::OP_ADD, nnalu_pkg::OP_SUB, nnalu_pkg::OP_CMP:
              state_nxt = nnalu_pkg::ST_ALU;
            nnalu_pkg::OP_MUL:
              state_nxt = nnalu_pkg::ST_MUL;
            nnalu_pkg::OP_DIV, nnalu_pkg::OP_MOD, nnalu_pkg::OP_GCD:
              state_nxt = nnalu_pkg::ST_CHK;
            default:
              state_nxt = nnalu_pkg::ST_FIN;
          endcase
        end
      end
      nnalu_pkg::ST_ALU: state_nxt = nnalu_pkg::ST_FIN;
      nnalu_pkg::ST_MUL: begin
        if (cnt_last) state_nxt = nnalu_pkg::ST_FIN;
      end
      nnalu_pkg::ST_CHK: begin
        state_nxt = y_zero ? nnalu_pkg::ST_FIN : nnalu_pkg::ST_DIV;
      end
      nnalu_pkg::ST_DIV: begin
        if (cnt_last) begin
          state_nxt = (op_r == nnalu_pkg::OP_GCD) ? nnalu_pkg::ST_CHK
                                                   : nnalu_pkg::ST_FIN;
        end
      end
      nnalu_pkg::ST_FIN: begin
        if (out_free) state_nxt = nnalu_pkg::ST_IDLE;
      end
      default: state_nxt = nnalu_pkg::ST_IDLE;
    endcase
  end

  // Datapath and output register
  always_comb begin
    op_nxt        = op_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    ord_nxt       = ord_r;
    flt_nxt       = flt_r;
    // drop the result once the receiver takes it
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      nnalu_pkg::ST_IDLE: begin
        if (in_fire) begin
          op_nxt  = in_data.opcode;
          x_nxt   = WIDTH'(in_data.operand_a);
          y_nxt   = WIDTH'(in_data.operand_b);
          acc_nxt = '0;
          cnt_nxt = '0;
          ord_nxt = nnalu_pkg::ORD_LESS;
          flt_nxt = nnalu_pkg::FLT_NONE;
        end
      end
      nnalu_pkg::ST_ALU: begin
        unique case (op_r)
          nnalu_pkg::OP_ADD: acc_nxt = u_res[WIDTH-1:0];
          nnalu_pkg::OP_SUB: begin
            if (u_stat.carry) begin
              acc_nxt = u_res[WIDTH-1:0];
            end else begin
              flt_nxt = nnalu_pkg::FLT_UNDER;
            end
          end
          default: begin
            // compare: borrow means less, zero difference means equal
            if (!u_stat.carry) ord_nxt = nnalu_pkg::ORD_LESS;
            else if (u_stat.zero) ord_nxt = nnalu_pkg::ORD_EQUAL;
            else ord_nxt = nnalu_pkg::ORD_GREATER;
          end
        endcase
      end
      nnalu_pkg::ST_MUL: begin
        if (y_r[0]) acc_nxt = u_res[WIDTH-1:0];
        x_nxt   = {x_r[WIDTH-2:0], 1'b0};
        y_nxt   = {1'b0, y_r[WIDTH-1:1]};
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      nnalu_pkg::ST_CHK: begin
        acc_nxt = '0;
        cnt_nxt = '0;
        if (y_zero) begin
          if (op_r == nnalu_pkg::OP_GCD) begin
            acc_nxt = x_r;
          end else begin
            flt_nxt = nnalu_pkg::FLT_ZERODIV;
          end
        end
      end
      nnalu_pkg::ST_DIV: begin
        acc_nxt = rem_step;
        x_nxt   = quo_step;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_last) begin
          unique case (op_r)
            nnalu_pkg::OP_DIV: acc_nxt = quo_step;
            nnalu_pkg::OP_MOD: acc_nxt = rem_step;
            default: begin
              // next Euclid round: (x, y) <- (y, x mod y)
              x_nxt = y_r;
              y_nxt = rem_step;
            end
          endcase
        end
      end
      nnalu_pkg::ST_FIN: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_data_nxt.value = FW'(acc_r);
          out_data_nxt.order = ord_r;
          out_data_nxt.fault = flt_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nnalu_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    acc_r      <= acc_nxt;
    ord_r      <= ord_nxt;
    flt_r      <= flt_nxt;
    out_data_r <= out_data_nxt;
  end

  // Only one item in flight: an accepted beat blocks the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> in_stall)
    else $error("input accepted while an item was in flight");

  // Faulted results carry a zero value
  a_fault_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.fault != nnalu_pkg::FLT_NONE) |-> (out_data.value == '0))
    else $error("faulted result with nonzero value");

  // A nonzero order code only comes from a compare, which has no value or fault
  a_order_only_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.order != nnalu_pkg::ORD_LESS) |->
      (out_data.value == '0) && (out_data.fault == nnalu_pkg::FLT_NONE))
    else $error("order code set on a non-compare result");

  // Each division round starts from a cleared bit counter
  a_div_starts_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nnalu_pkg::ST_CHK) |=> (cnt_r == '0))
    else $error("division round started with stale counter");

endmodule

[verif/tb_natural_number_alu_with_gcd.sv]
`timescale 1ns / 100ps
// Self-checking testbench for natural_number_alu_with_gcd: directed corner beats, then
// random traffic with idles, back-pressure and drain pauses on both handshakes.
// Depends on nnalu_pkg and the RTL of the block.
module tb_natural_number_alu_with_gcd;

  localparam int W              = nnalu_pkg::WIDTH_DEF;
  localparam int FW             = nnalu_pkg::FIELD_W;
  localparam int RANDOM_BEATS   = 350;
  localparam int HOLD_CYCLES    = 3000;   // long receiver hold-off
  localparam int TAIL_CYCLES    = 64;     // settle time after the last result
  localparam int WATCHDOG_LIMIT = 20000;  // idle cycles before giving up
  localparam int REPORT_CAP     = 40;
  localparam logic [2:0] OP_SPARE = 3'd7; // unused opcode, must give all zeros

  // One planned input beat plus the traffic shaping attached to it.
  typedef struct {
    nnalu_pkg::in_item_t beat;
    int unsigned         gap;    // idle cycles after this beat is taken
    bit                  drain;  // wait for every result before offering it
    bit                  hold;   // start the long receiver hold-off when offered
    bit                  calm;   // no receiver stalls while this beat is current
  } plan_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  nnalu_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  nnalu_pkg::out_item_t out_data;

  plan_t                beat_plan[$];
  nnalu_pkg::out_item_t due_results[$];
  int unsigned beats_issued = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  logic        hold_req = 1'b0;
  logic        rx_calm = 1'b0;

  natural_number_alu_with_gcd #(
    .WIDTH(W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Compute the result beat the ALU owes for one input beat.
  function automatic nnalu_pkg::out_item_t alu_result(nnalu_pkg::in_item_t beat);
    nnalu_pkg::out_item_t r;
    logic [W-1:0] x, y, t;
    r = '0;
    x = beat.operand_a[W-1:0];
    y = beat.operand_b[W-1:0];
    case (beat.opcode)
      nnalu_pkg::OP_ADD: r.value = x + y;
      nnalu_pkg::OP_SUB: begin
        if (x >= y) r.value = x - y;
        else r.fault = nnalu_pkg::FLT_UNDER;
      end
      nnalu_pkg::OP_MUL: r.value = x * y;
      nnalu_pkg::OP_DIV: begin
        if (y != '0) r.value = x / y;
        else r.fault = nnalu_pkg::FLT_ZERODIV;
      end
      nnalu_pkg::OP_MOD: begin
        if (y != '0) r.value = x % y;
        else r.fault = nnalu_pkg::FLT_ZERODIV;
      end
      nnalu_pkg::OP_CMP: begin
        if (x < y) r.order = nnalu_pkg::ORD_LESS;
        else if (x > y) r.order = nnalu_pkg::ORD_GREATER;
        else r.order = nnalu_pkg::ORD_EQUAL;
      end
      nnalu_pkg::OP_GCD: begin
        // Euclid by repeated remainder; a zero operand yields the other one
        while (y != '0) begin
          t = x % y;
          x = y;
          y = t;
        end
        r.value = x;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // Mostly back-to-back, some short idles, now and then a long one.
  function automatic int unsigned random_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    else if (pick < 90) return $urandom_range(1, 3);
    else return $urandom_range(20, 80);
  endfunction

  // Spread operands over full range, tiny values, near-max values, single bits and 16-bit values.
  function automatic logic [FW-1:0] random_operand();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 15);
      1: return {FW{1'b1}} - $urandom_range(0, 15);
      2: return 32'd1 << $urandom_range(0, FW - 1);
      3: return $urandom_range(0, 65535);
      default: return $urandom;
    endcase
  endfunction

  function automatic nnalu_pkg::in_item_t random_beat();
    nnalu_pkg::in_item_t b;
    int unsigned         g;
    if ($urandom_range(0, 99) < 3) b.opcode = OP_SPARE;
    else b.opcode = 3'($urandom_range(nnalu_pkg::OP_ADD, nnalu_pkg::OP_GCD));
    b.operand_a = random_operand();
    case ($urandom_range(0, 9))
      0: b.operand_b = b.operand_a;
      1: b.operand_b = '0;
      2: begin
        b.operand_b = random_operand();
        b.operand_a = '0;
      end
      3: begin
        // shared factor so gcd and remainder land on something nontrivial
        g = $urandom_range(1, 1000);
        b.operand_a = g * $urandom_range(1, 100000);
        b.operand_b = g * $urandom_range(1, 100000);
      end
      default: b.operand_b = random_operand();
    endcase
    return b;
  endfunction

  task automatic plan_beat(logic [2:0] op, logic [FW-1:0] a, logic [FW-1:0] b);
    plan_t p;
    p.beat.opcode    = op;
    p.beat.operand_a = a;
    p.beat.operand_b = b;
    p.gap   = random_gap();
    p.drain = 1'b0;
    p.hold  = 1'b0;
    p.calm  = 1'b0;
    beat_plan.push_back(p);
  endtask

  // Driver: present planned beats, log the expected result at each taken beat.
  always @(posedge clk) begin : drive
    logic  in_fire;
    logic  next_hold;
    plan_t cur;
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_data      <= '0;
      gap_left     <= 0;
      hold_req     <= 1'b0;
      rx_calm      <= 1'b0;
      beats_issued <= 0;
    end else begin
      in_fire   = in_valid && !in_stall;
      next_hold = 1'b0;
      if (in_fire) begin
        due_results.push_back(alu_result(in_data));
        beats_issued <= beats_issued + 1;
      end
      // Hold a stalled payload; only move on once the current beat is gone.
      if (!in_valid || in_fire) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (beat_plan.size() != 0 &&
                     (!beat_plan[0].drain || (!in_fire && beats_issued == results_seen))) begin
          cur = beat_plan.pop_front();
          in_valid  <= 1'b1;
          in_data   <= cur.beat;
          gap_left  <= cur.gap;
          rx_calm   <= cur.calm;
          next_hold = cur.hold;
        end else begin
          in_valid <= 1'b0;
        end
      end
      hold_req <= next_hold;
    end
  end

  // Monitor: check each result beat against the oldest expectation, and
  // generate receiver stalls.
  always @(posedge clk) begin : monitor
    nnalu_pkg::out_item_t exp_beat;
    int unsigned          pick;
    if (!rst_n) begin
      out_stall    <= 1'b0;
      stall_left   <= 0;
      results_seen <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("%0t unexpected result beat: expected none, actual %h", $time, out_data);
        end else begin
          exp_beat = due_results.pop_front();
          if (out_data.value !== exp_beat.value) begin
            errors++;
            if (errors <= REPORT_CAP)
              $display("%0t value mismatch: expected %h, actual %h",
                       $time, exp_beat.value, out_data.value);
          end
          if (out_data.order !== exp_beat.order) begin
            errors++;
            if (errors <= REPORT_CAP)
              $display("%0t order mismatch: expected %0d, actual %0d",
                       $time, exp_beat.order, out_data.order);
          end
          if (out_data.fault !== exp_beat.fault) begin
            errors++;
            if (errors <= REPORT_CAP)
              $display("%0t fault mismatch: expected %0d, actual %0d",
                       $time, exp_beat.fault, out_data.fault);
          end
        end
      end
      // Long hold-off wins over everything; then finish a running stall,
      // then either run clean or roll a fresh stall.
      if (hold_req) begin
        out_stall  <= 1'b1;
        stall_left <= HOLD_CYCLES;
      end else if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (rx_calm) begin
        out_stall <= 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          out_stall <= 1'b0;
        end else if (pick < 97) begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(0, 3);
        end else begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(20, 120);
        end
      end
    end
  end

  // Watchdog: give up if no beat moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no handshake for %0d cycles", $time, quiet_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    plan_t p;
    // Directed corners: wraps, underflow, zero divisors, all compare codes,
    // gcd with zero operands, the worst-case gcd pair, unused opcode.
    plan_beat(nnalu_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    plan_beat(nnalu_pkg::OP_ADD, 32'h0, 32'h0);
    plan_beat(nnalu_pkg::OP_ADD, 32'hFFFF_FFFF, 32'h1);
    plan_beat(nnalu_pkg::OP_SUB, 32'h1234_5678, 32'h1234_5678);
    plan_beat(nnalu_pkg::OP_SUB, 32'h0, 32'hFFFF_FFFF);
    plan_beat(nnalu_pkg::OP_SUB, 32'hFFFF_FFFF, 32'h0);
    plan_beat(nnalu_pkg::OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    plan_beat(nnalu_pkg::OP_MUL, 32'h0001_0000, 32'h0001_0000);
    plan_beat(nnalu_pkg::OP_DIV, 32'hDEAD_BEEF, 32'h0);
    plan_beat(nnalu_pkg::OP_DIV, 32'hFFFF_FFFF, 32'h1);
    plan_beat(nnalu_pkg::OP_DIV, 32'd7, 32'd9);
    plan_beat(nnalu_pkg::OP_MOD, 32'h0, 32'h0);
    plan_beat(nnalu_pkg::OP_MOD, 32'hFFFF_FFFF, 32'h10);
    plan_beat(nnalu_pkg::OP_CMP, 32'h0, 32'hFFFF_FFFF);
    plan_beat(nnalu_pkg::OP_CMP, 32'hAAAA_5555, 32'hAAAA_5555);
    plan_beat(nnalu_pkg::OP_CMP, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    plan_beat(nnalu_pkg::OP_GCD, 32'hCAFE_F00D, 32'h0);
    plan_beat(nnalu_pkg::OP_GCD, 32'h0, 32'h8000_0000);
    plan_beat(nnalu_pkg::OP_GCD, 32'h0, 32'h0);
    plan_beat(nnalu_pkg::OP_GCD, 32'd1836311903, 32'd2971215073);  // consecutive Fibonacci
    plan_beat(nnalu_pkg::OP_GCD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    plan_beat(nnalu_pkg::OP_GCD, 32'd12, 32'd18);
    plan_beat(OP_SPARE, 32'hFFFF_FFFF, 32'h5555_AAAA);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      p.beat  = random_beat();
      p.gap   = random_gap();
      p.drain = (n == 0) || (n == 180);    // pause until the block is empty
      p.hold  = (n == 70);                 // receiver holds off, sender keeps pushing
      p.calm  = (n >= 250 && n < 290);     // stretch with no idling at all
      if (p.calm || (n >= 70 && n < 80)) p.gap = 0;
      beat_plan.push_back(p);
    end

    // Hold reset at the start, once.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every beat to be taken, then for every result to return.
    while (beat_plan.size() != 0 || in_valid) @(posedge clk);
    while (results_seen < beats_issued) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (due_results.size() != 0) begin
      errors++;
      $display("%0t %0d expected results never arrived", $time, due_results.size());
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
